// ----- design/remote_id_location_encoder_core_assert.svh -----
// ----------------------------------------------------------------------------
// Remote ID location encoder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef REMOTE_ID_LOCATION_ENCODER_CORE_ASSERT_SVH
`define REMOTE_ID_LOCATION_ENCODER_CORE_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define RID_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define RID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/rid_pkg.sv -----
// ----------------------------------------------------------------------------
// Remote ID location encoder package
// Shared types, codes, constants and the altitude encoding function.
// ----------------------------------------------------------------------------
package rid_pkg;

  localparam logic [4:0] LAST_IDX = 5'd24;

  localparam int CQ_DEPTH = 4;
  localparam int RQ_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_FIX     = 2'd0,
    CMD_BUILD   = 2'd1,
    CMD_CLR_LOC = 2'd2,
    CMD_CLR_TKO = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_ACCEPT  = 3'd0,
    KIND_REJECT  = 3'd1,
    KIND_BYTE    = 3'd2,
    KIND_NO_LOC  = 3'd3,
    KIND_CLEARED = 3'd4
  } kind_t;

  typedef enum logic {
    OP_SINGLE = 1'b0,
    OP_BUILD  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE   = 2'd0,
    BK_PREP   = 2'd1,
    BK_STREAM = 2'd2
  } bk_state_t;

  typedef struct packed {
    op_t         op;
    kind_t       kind;
    logic [31:0] lat;
    logic [31:0] lon;
    logic [15:0] alt;
    logic [15:0] spd;
    logic [15:0] dir;
    logic        tko_valid;
    logic [15:0] tko_alt;
  } cq_entry_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [4:0] idx;
    logic       last;
  } res_t;

  localparam logic signed [31:0] LAT_MAX = 32'sd900000000;
  localparam logic signed [31:0] LAT_MIN = -32'sd900000000;
  localparam logic signed [31:0] LON_MAX = 32'sd1800000000;
  localparam logic signed [31:0] LON_MIN = -32'sd1800000000;
  localparam logic signed [15:0] ALT_MAX = 16'sd31767;
  localparam logic signed [15:0] ALT_MIN = -16'sd1000;

  localparam logic [15:0] DIR_INVALID = 16'd36100;
  localparam logic [16:0] DIR_RND     = 17'd50;
  localparam logic [16:0] DIV100_K    = 17'd83887;
  localparam int          DIV100_S    = 23;
  localparam logic [8:0]  DEG_FULL    = 9'd360;
  localparam logic [8:0]  DEG_MAX     = 9'd359;
  localparam logic [8:0]  DEG_HALF    = 9'd180;

  localparam logic [15:0] SPD_AIR     = 16'd200;
  localparam logic [15:0] SPD_SAT     = 16'd25500;
  localparam logic [15:0] SPD_LOW_MAX = 16'd6375;
  localparam logic [16:0] SPD_LOW_RND = 17'd12;
  localparam logic [15:0] SPD_HI_OFS  = 16'd6338;
  localparam logic [13:0] DIV25_K     = 14'd10486;
  localparam int          DIV25_S     = 18;
  localparam logic [14:0] DIV75_K     = 15'd27963;
  localparam int          DIV75_S     = 21;
  localparam logic [8:0]  CODE_MAX    = 9'd255;

  localparam logic signed [15:0] HGT_AIR_POS = 16'sd3;
  localparam logic signed [15:0] HGT_AIR_NEG = -16'sd3;

  localparam logic [7:0] MSG_HDR  = 8'h12;
  localparam logic [7:0] MSG_FILL = 8'hFF;

  localparam logic signed [17:0] ALT_OFS = 18'sd1000;
  localparam logic signed [17:0] ENC_MAX = 18'sd65535;

  // Altitude code: (m + 1000) * 2, saturated to the 16-bit range.
  function automatic logic [15:0] enc_alt(input logic signed [15:0] m);
    logic signed [17:0] e;
    e = ($signed({{2{m[15]}}, m}) + ALT_OFS) <<< 1;
    if (e < 0) begin
      return 16'd0;
    end else if (e > ENC_MAX) begin
      return 16'hFFFF;
    end else begin
      return e[15:0];
    end
  endfunction

endpackage

// ----- design/rid_fifo.sv -----
// ----------------------------------------------------------------------------
// Remote ID location encoder queue
// Small register FIFO with full and empty flags; DEPTH of two or more.
// ----------------------------------------------------------------------------
module rid_fifo #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             wr_en;
  logic             rd_en;

  assign full  = (cnt_r == CNT_FULL);
  assign empty = (cnt_r == '0);
  assign wr_en = push & ~full;
  assign rd_en = pop & ~empty;
  assign dout  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= din;
    end
  end

endmodule

// ----- design/rid_front.sv -----
// ----------------------------------------------------------------------------
// Remote ID location encoder front end
// Accepts requests, checks fixes, holds the location and takeoff state and
// queues one classified entry per request for the back end.
// ----------------------------------------------------------------------------
module rid_front
  import rid_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic [1:0]         in_cmd,
  input  logic signed [31:0] in_lat_e7,
  input  logic signed [31:0] in_lon_e7,
  input  logic signed [15:0] in_alt_m,
  input  logic [15:0]        in_speed_cms,
  input  logic [15:0]        in_dir_cdeg,
  input  logic               cq_full,
  output logic               cq_push,
  output cq_entry_t          cq_data
);

  logic        loc_valid_r, loc_valid_nxt;
  logic [31:0] loc_lat_r, loc_lat_nxt;
  logic [31:0] loc_lon_r, loc_lon_nxt;
  logic [15:0] loc_alt_r, loc_alt_nxt;
  logic [15:0] loc_speed_r, loc_speed_nxt;
  logic [15:0] loc_dir_r, loc_dir_nxt;
  logic        tko_valid_r, tko_valid_nxt;
  logic [15:0] tko_alt_r, tko_alt_nxt;
  logic        accept;
  logic        fix_bad;
  logic [15:0] dir_clamp;

  assign accept  = in_push & ~cq_full;
  assign cq_push = accept;

  assign fix_bad = (in_lat_e7 < LAT_MIN) || (in_lat_e7 > LAT_MAX) ||
                   (in_lon_e7 < LON_MIN) || (in_lon_e7 > LON_MAX) ||
                   (in_alt_m < ALT_MIN) || (in_alt_m > ALT_MAX) ||
                   ((in_lat_e7 == '0) && (in_lon_e7 == '0));
  assign dir_clamp = (in_dir_cdeg > DIR_INVALID) ? DIR_INVALID : in_dir_cdeg;

  always_comb begin
    loc_valid_nxt = loc_valid_r;
    loc_lat_nxt   = loc_lat_r;
    loc_lon_nxt   = loc_lon_r;
    loc_alt_nxt   = loc_alt_r;
    loc_speed_nxt = loc_speed_r;
    loc_dir_nxt   = loc_dir_r;
    tko_valid_nxt = tko_valid_r;
    tko_alt_nxt   = tko_alt_r;

    cq_data           = '0;
    cq_data.op        = OP_SINGLE;
    cq_data.lat       = loc_lat_r;
    cq_data.lon       = loc_lon_r;
    cq_data.alt       = loc_alt_r;
    cq_data.spd       = loc_speed_r;
    cq_data.dir       = loc_dir_r;
    cq_data.tko_valid = tko_valid_r;
    cq_data.tko_alt   = tko_alt_r;

    unique case (cmd_t'(in_cmd))
      CMD_FIX: begin
        if (fix_bad) begin
          cq_data.kind = KIND_REJECT;
        end else begin
          cq_data.kind = KIND_ACCEPT;
          if (accept) begin
            loc_valid_nxt = 1'b1;
            loc_lat_nxt   = in_lat_e7;
            loc_lon_nxt   = in_lon_e7;
            loc_alt_nxt   = in_alt_m;
            loc_speed_nxt = in_speed_cms;
            loc_dir_nxt   = dir_clamp;
            if (!tko_valid_r) begin
              tko_valid_nxt = 1'b1;
              tko_alt_nxt   = in_alt_m;
            end
          end
        end
      end
      CMD_BUILD: begin
        if (loc_valid_r) begin
          cq_data.op   = OP_BUILD;
          cq_data.kind = KIND_BYTE;
        end else begin
          cq_data.kind = KIND_NO_LOC;
        end
      end
      CMD_CLR_LOC: begin
        cq_data.kind = KIND_CLEARED;
        if (accept) begin
          loc_valid_nxt = 1'b0;
        end
      end
      CMD_CLR_TKO: begin
        cq_data.kind = KIND_CLEARED;
        if (accept) begin
          tko_valid_nxt = 1'b0;
        end
      end
      default: begin
        cq_data.kind = KIND_CLEARED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loc_valid_r <= 1'b0;
      tko_valid_r <= 1'b0;
    end else begin
      loc_valid_r <= loc_valid_nxt;
      tko_valid_r <= tko_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    loc_lat_r   <= loc_lat_nxt;
    loc_lon_r   <= loc_lon_nxt;
    loc_alt_r   <= loc_alt_nxt;
    loc_speed_r <= loc_speed_nxt;
    loc_dir_r   <= loc_dir_nxt;
    tko_alt_r   <= tko_alt_nxt;
  end

endmodule

// ----- design/rid_back.sv -----
// ----------------------------------------------------------------------------
// Remote ID location encoder back end
// Takes queued entries, encodes the location message fields and streams the
// message bytes or the single result into the result queue.
// ----------------------------------------------------------------------------
`include "remote_id_location_encoder_core_assert.svh"

module rid_back
  import rid_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cq_empty,
  input  cq_entry_t cq_data,
  output logic      cq_pop,
  input  logic      rq_full,
  output logic      rq_push,
  output res_t      rq_data
);

  bk_state_t   state_r, state_nxt;
  logic [4:0]  idx_r, idx_nxt;
  cq_entry_t   ent_r;

  logic        air_r;
  logic        dir_ok_r;
  logic [8:0]  dir_q_r;
  logic        spd_sat_r;
  logic        spd_hs_r;
  logic [8:0]  spd_q_r;
  logic [15:0] alt_enc_r;
  logic [15:0] hgt_enc_r;

  logic signed [15:0] hgt;
  logic [16:0] dir_x;
  logic [33:0] dir_prod;
  logic [16:0] spd_lo_x;
  logic [30:0] spd_lo_prod;
  logic [15:0] spd_hi_x;
  logic [30:0] spd_hi_prod;
  logic        spd_hs;

  logic [8:0]  deg;
  logic        west;
  logic [7:0]  dir_byte;
  logic [7:0]  spd_byte;
  logic [7:0]  msg_byte;

  assign hgt = ent_r.tko_valid ? $signed(ent_r.alt) - $signed(ent_r.tko_alt) : '0;
  assign dir_x       = {1'b0, ent_r.dir} + DIR_RND;
  assign dir_prod    = 34'(dir_x) * 34'(DIV100_K);
  assign spd_lo_x    = {1'b0, ent_r.spd} + SPD_LOW_RND;
  assign spd_lo_prod = 31'(spd_lo_x) * 31'(DIV25_K);
  assign spd_hi_x    = ent_r.spd - SPD_HI_OFS;
  assign spd_hi_prod = 31'(spd_hi_x) * 31'(DIV75_K);
  assign spd_hs      = ent_r.spd > SPD_LOW_MAX;

  always_ff @(posedge clk) begin
    if (state_r == BK_PREP) begin
      air_r     <= (ent_r.spd >= SPD_AIR) || (hgt >= HGT_AIR_POS) || (hgt <= HGT_AIR_NEG);
      dir_ok_r  <= ent_r.dir < DIR_INVALID;
      dir_q_r   <= dir_prod[DIV100_S +: 9];
      spd_sat_r <= ent_r.spd >= SPD_SAT;
      spd_hs_r  <= spd_hs & ~(ent_r.spd >= SPD_SAT);
      spd_q_r   <= spd_hs ? spd_hi_prod[DIV75_S +: 9] : spd_lo_prod[DIV25_S +: 9];
      alt_enc_r <= enc_alt($signed(ent_r.alt));
      hgt_enc_r <= enc_alt(hgt);
    end
  end

  always_comb begin
    deg  = dir_q_r;
    west = 1'b0;
    if (deg == DEG_FULL) begin
      deg = '0;
    end else if (deg > DEG_FULL) begin
      deg = DEG_MAX;
    end
    if (deg >= DEG_HALF) begin
      deg  = deg - DEG_HALF;
      west = 1'b1;
    end
    dir_byte = dir_ok_r ? deg[7:0] : 8'd0;
    west     = west & dir_ok_r;
    if (spd_sat_r || (spd_q_r > CODE_MAX)) begin
      spd_byte = 8'hFF;
    end else begin
      spd_byte = spd_q_r[7:0];
    end
  end

  always_comb begin
    unique case (idx_r)
      5'd0:    msg_byte = MSG_HDR;
      5'd1:    msg_byte = {2'b00, air_r, ~air_r, 2'b00, west, spd_hs_r};
      5'd2:    msg_byte = dir_byte;
      5'd3:    msg_byte = spd_byte;
      5'd5:    msg_byte = ent_r.lat[7:0];
      5'd6:    msg_byte = ent_r.lat[15:8];
      5'd7:    msg_byte = ent_r.lat[23:16];
      5'd8:    msg_byte = ent_r.lat[31:24];
      5'd9:    msg_byte = ent_r.lon[7:0];
      5'd10:   msg_byte = ent_r.lon[15:8];
      5'd11:   msg_byte = ent_r.lon[23:16];
      5'd12:   msg_byte = ent_r.lon[31:24];
      5'd13:   msg_byte = alt_enc_r[7:0];
      5'd14:   msg_byte = alt_enc_r[15:8];
      5'd15:   msg_byte = alt_enc_r[7:0];
      5'd16:   msg_byte = alt_enc_r[15:8];
      5'd17:   msg_byte = hgt_enc_r[7:0];
      5'd18:   msg_byte = hgt_enc_r[15:8];
      5'd21:   msg_byte = MSG_FILL;
      5'd22:   msg_byte = MSG_FILL;
      default: msg_byte = 8'd0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cq_pop    = 1'b0;
    rq_push   = 1'b0;
    rq_data   = '0;
    unique case (state_r)
      BK_IDLE: begin
        if (!cq_empty && !rq_full) begin
          cq_pop = 1'b1;
          if (cq_data.op == OP_BUILD) begin
            state_nxt = BK_PREP;
          end else begin
            rq_push      = 1'b1;
            rq_data.kind = cq_data.kind;
            rq_data.last = 1'b1;
          end
        end
      end
      BK_PREP: begin
        state_nxt = BK_STREAM;
        idx_nxt   = '0;
      end
      BK_STREAM: begin
        if (!rq_full) begin
          rq_push      = 1'b1;
          rq_data.kind = KIND_BYTE;
          rq_data.data = msg_byte;
          rq_data.idx  = idx_r;
          rq_data.last = (idx_r == LAST_IDX);
          if (idx_r == LAST_IDX) begin
            state_nxt = BK_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cq_pop) begin
      ent_r <= cq_data;
    end
  end

  `RID_ASSERT_SAME(a_idx_in_msg, state_r == BK_STREAM, idx_r <= LAST_IDX, "Byte index ran past the message end.")
  `RID_ASSERT_NEXT(a_prep_to_stream, state_r == BK_PREP, state_r == BK_STREAM && idx_r == '0, "Encode cycle did not start the stream.")
  `RID_ASSERT_NEXT(a_last_ends, state_r == BK_STREAM && rq_push && idx_r == LAST_IDX, state_r == BK_IDLE, "Stream did not end after the last byte.")
  `RID_ASSERT_SAME(a_push_room, rq_push, !rq_full, "Result pushed into a full queue.")

endmodule

// ----- design/remote_id_location_encoder_core.sv -----
// ----------------------------------------------------------------------------
// Remote ID location encoder core
// Holds the latest fix and the takeoff fix and streams the 25-byte location
// message on request.
// ----------------------------------------------------------------------------
// A fix update or a clear request is taken in the cycle it arrives unless the
// command queue is full, and gives one result; such requests flow at one per
// cycle while no queue is full. A build request occupies the back end to load
// the entry, encode the message fields with the divide-by-constant multipliers
// and stream one message byte per cycle, while the result queue has room,
// through the single result port. The command queue (CMD_DEPTH entries) lets new
// requests be taken while a message is still streaming, and the result queue
// (RES_DEPTH entries) keeps the back end running while results wait to be popped.
module remote_id_location_encoder_core
  import rid_pkg::*;
#(
  parameter int CMD_DEPTH = CQ_DEPTH,
  parameter int RES_DEPTH = RQ_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [1:0]         in_cmd,
  input  logic signed [31:0] in_lat_e7,
  input  logic signed [31:0] in_lon_e7,
  input  logic signed [15:0] in_alt_m,
  input  logic [15:0]        in_speed_cms,
  input  logic [15:0]        in_dir_cdeg,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [2:0]         out_kind,
  output logic [7:0]         out_data_byte,
  output logic [4:0]         out_byte_index,
  output logic               out_last
);

  localparam int CQ_W = $bits(cq_entry_t);
  localparam int RQ_W = $bits(res_t);

  logic      cq_push;
  logic      cq_full;
  logic      cq_pop;
  logic      cq_empty;
  cq_entry_t cq_din;
  cq_entry_t cq_dout;
  logic      rq_push;
  logic      rq_full;
  res_t      rq_din;
  res_t      rq_dout;

  assign in_full = cq_full;

  rid_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_cmd       (in_cmd),
    .in_lat_e7    (in_lat_e7),
    .in_lon_e7    (in_lon_e7),
    .in_alt_m     (in_alt_m),
    .in_speed_cms (in_speed_cms),
    .in_dir_cdeg  (in_dir_cdeg),
    .cq_full      (cq_full),
    .cq_push      (cq_push),
    .cq_data      (cq_din)
  );

  rid_fifo #(
    .DEPTH (CMD_DEPTH),
    .WIDTH (CQ_W)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cq_push),
    .din   (cq_din),
    .full  (cq_full),
    .pop   (cq_pop),
    .dout  (cq_dout),
    .empty (cq_empty)
  );

  rid_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cq_empty (cq_empty),
    .cq_data  (cq_dout),
    .cq_pop   (cq_pop),
    .rq_full  (rq_full),
    .rq_push  (rq_push),
    .rq_data  (rq_din)
  );

  rid_fifo #(
    .DEPTH (RES_DEPTH),
    .WIDTH (RQ_W)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rq_push),
    .din   (rq_din),
    .full  (rq_full),
    .pop   (out_pop),
    .dout  (rq_dout),
    .empty (out_empty)
  );

  assign out_kind       = rq_dout.kind;
  assign out_data_byte  = rq_dout.data;
  assign out_byte_index = rq_dout.idx;
  assign out_last       = rq_dout.last;

endmodule
